[hdl/rbd_pkg.sv]
package rbd_pkg;

   localparam int DEPTH     = 1024;
   localparam int WORD_BITS = 32;
   localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   localparam int KIND_W    = 3;
   localparam int INDEX_W   = 10;
   localparam int VALUE_W   = 32;
   localparam int SIZE_W    = 11;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 11;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_BACK  = 3'd0,
      KIND_PUSH_FRONT = 3'd1,
      KIND_POP_BACK   = 3'd2,
      KIND_POP_FRONT  = 3'd3,
      KIND_GET        = 3'd4,
      KIND_SET        = 3'd5,
      KIND_RESIZE     = 3'd6,
      KIND_CLEAR      = 3'd7
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 3'd0,
      STATUS_FULL  = 3'd1,
      STATUS_EMPTY = 3'd2,
      STATUS_RANGE = 3'd3,
      STATUS_SIZE  = 3'd4
   } status_type;

   typedef struct packed {
      kind_type                    kind;
      logic [INDEX_W-1:0]          index;
      logic signed [VALUE_W-1:0]   value;
      logic [SIZE_W-1:0]           target_len;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]   data;
      status_type                  status;
      logic [COUNT_W-1:0]          count;
      logic                        is_empty;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic finish_read;
      logic sweep;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic need_read;
      logic need_sweep;
      logic sweep_last;
   } dp_status_type;

   function automatic logic [PTR_BITS-1:0] wrap_inc(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
   endfunction

   function automatic logic [PTR_BITS-1:0] wrap_dec(input logic [PTR_BITS-1:0] p);
      return (p == '0) ? PTR_BITS'(DEPTH - 1) : p - PTR_BITS'(1);
   endfunction

   // offset never exceeds DEPTH, so one subtract brings the sum back in range
   function automatic logic [PTR_BITS-1:0] wrap_add(input logic [PTR_BITS-1:0] p,
                                                    input logic [CNT_BITS-1:0] o);
      logic [CNT_BITS:0] s;
      s = (CNT_BITS+1)'(p) + (CNT_BITS+1)'(o);
      if (s >= (CNT_BITS+1)'(DEPTH)) begin
         s = s - (CNT_BITS+1)'(DEPTH);
      end
      return PTR_BITS'(s);
   endfunction

   function automatic logic [WORD_BITS-1:0] word_in(input logic signed [VALUE_W-1:0] v);
      return WORD_BITS'(v);
   endfunction

   function automatic logic signed [VALUE_W-1:0] word_out(input logic [WORD_BITS-1:0] w);
      return VALUE_W'(signed'(w));
   endfunction

endpackage

[hdl/rbd_ram.sv]
module rbd_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 1024,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/rbd_ctrl.sv]
module rbd_ctrl import rbd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   typedef enum logic [4:0] {
      ST_INIT  = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_READ  = 5'b01000,
      ST_SWEEP = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            // zero the store after reset, no word goes out
            cmd.sweep = 1'b1;
            if (dp_status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            priority if (dp_status.need_read) begin
               state_in = ST_READ;
            end else if (dp_status.need_sweep) begin
               state_in = ST_SWEEP;
            end else begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.finish_read = 1'b1;
            cmd.respond     = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (dp_status.sweep_last) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[hdl/rbd_dpath.sv]
module rbd_dpath import rbd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_word,
   input  cmd_type       cmd,
   output dp_status_type dp_status,
   output logic          rsp_strobe,
   output rsp_type       rsp_word
);

   req_type              req_ff, req_in;
   logic [PTR_BITS-1:0]  head_ff, head_in;
   logic [PTR_BITS-1:0]  tail_ff, tail_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [PTR_BITS-1:0]  slot_ff, slot_in;
   status_type           status_ff, status_in;
   logic [PTR_BITS-1:0]  sweep_ptr_ff, sweep_ptr_in;
   logic [CNT_BITS-1:0]  sweep_left_ff, sweep_left_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;

   status_type           status_c;
   logic                 ok_c;
   logic [PTR_BITS-1:0]  slot_c;
   logic [CNT_BITS-1:0]  nsize_c;
   logic [PTR_BITS-1:0]  new_tail_c;

   logic                 wr_en;
   logic [PTR_BITS-1:0]  wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [PTR_BITS-1:0]  rd_addr;
   logic [WORD_BITS-1:0] rd_data;

   rbd_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         cnt_ff        <= '0;
         sweep_ptr_ff  <= '0;
         sweep_left_ff <= CNT_BITS'(DEPTH);
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         cnt_ff        <= cnt_in;
         sweep_ptr_ff  <= sweep_ptr_in;
         sweep_left_ff <= sweep_left_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   // index is below the count when valid, so it fits a pointer
   assign slot_c     = wrap_add(head_ff, CNT_BITS'(PTR_BITS'(req_ff.index)));
   assign nsize_c    = CNT_BITS'(req_ff.target_len);
   assign new_tail_c = wrap_add(head_ff, nsize_c);

   always_comb begin
      unique case (req_ff.kind)
         KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
            status_c = (cnt_ff == CNT_BITS'(DEPTH)) ? STATUS_FULL : STATUS_OK;
         end
         KIND_POP_BACK, KIND_POP_FRONT: begin
            status_c = (cnt_ff == '0) ? STATUS_EMPTY : STATUS_OK;
         end
         KIND_GET, KIND_SET: begin
            status_c = (32'(req_ff.index) >= 32'(cnt_ff)) ? STATUS_RANGE : STATUS_OK;
         end
         KIND_RESIZE: begin
            status_c = (32'(req_ff.target_len) > 32'(DEPTH)) ? STATUS_SIZE : STATUS_OK;
         end
         default: begin
            status_c = STATUS_OK;
         end
      endcase
   end

   assign ok_c = (status_c == STATUS_OK);

   assign dp_status.need_read = ok_c && (req_ff.kind == KIND_POP_BACK ||
                                         req_ff.kind == KIND_POP_FRONT ||
                                         req_ff.kind == KIND_GET);
   assign dp_status.need_sweep = ok_c && ((req_ff.kind == KIND_RESIZE && nsize_c < cnt_ff) ||
                                          req_ff.kind == KIND_CLEAR);
   assign dp_status.sweep_last = (sweep_left_ff == CNT_BITS'(1));

   always_comb begin
      req_in        = req_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cnt_in        = cnt_ff;
      slot_in       = slot_ff;
      status_in     = status_ff;
      sweep_ptr_in  = sweep_ptr_ff;
      sweep_left_in = sweep_left_ff;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      wr_data       = '0;
      rd_addr       = head_ff;

      if (cmd.load) begin
         req_in = req_word;
      end

      if (cmd.exec) begin
         status_in = status_c;
         if (ok_c) begin
            unique case (req_ff.kind)
               KIND_PUSH_BACK: begin
                  wr_en   = 1'b1;
                  wr_addr = tail_ff;
                  wr_data = word_in(req_ff.value);
                  tail_in = wrap_inc(tail_ff);
                  cnt_in  = cnt_ff + CNT_BITS'(1);
               end
               KIND_PUSH_FRONT: begin
                  wr_en   = 1'b1;
                  wr_addr = wrap_dec(head_ff);
                  wr_data = word_in(req_ff.value);
                  head_in = wrap_dec(head_ff);
                  cnt_in  = cnt_ff + CNT_BITS'(1);
               end
               KIND_POP_BACK: begin
                  rd_addr = wrap_dec(tail_ff);
                  slot_in = wrap_dec(tail_ff);
                  tail_in = wrap_dec(tail_ff);
                  cnt_in  = cnt_ff - CNT_BITS'(1);
               end
               KIND_POP_FRONT: begin
                  rd_addr = head_ff;
                  slot_in = head_ff;
                  head_in = wrap_inc(head_ff);
                  cnt_in  = cnt_ff - CNT_BITS'(1);
               end
               KIND_GET: begin
                  rd_addr = slot_c;
                  slot_in = slot_c;
               end
               KIND_SET: begin
                  wr_en   = 1'b1;
                  wr_addr = slot_c;
                  wr_data = word_in(req_ff.value);
               end
               KIND_RESIZE: begin
                  // slots beyond the new tail up to the old count get zeroed
                  cnt_in        = nsize_c;
                  tail_in       = new_tail_c;
                  sweep_ptr_in  = new_tail_c;
                  sweep_left_in = (nsize_c < cnt_ff) ? cnt_ff - nsize_c : '0;
               end
               KIND_CLEAR: begin
                  head_in       = '0;
                  tail_in       = '0;
                  cnt_in        = '0;
                  sweep_ptr_in  = '0;
                  sweep_left_in = CNT_BITS'(DEPTH);
               end
               default: begin
                  cnt_in = cnt_ff;
               end
            endcase
         end
      end

      // drop the popped word from the store once it has been read
      if (cmd.finish_read && (req_ff.kind == KIND_POP_BACK ||
                              req_ff.kind == KIND_POP_FRONT)) begin
         wr_en   = 1'b1;
         wr_addr = slot_ff;
         wr_data = '0;
      end

      if (cmd.sweep) begin
         wr_en         = 1'b1;
         wr_addr       = sweep_ptr_ff;
         wr_data       = '0;
         sweep_ptr_in  = wrap_inc(sweep_ptr_ff);
         sweep_left_in = sweep_left_ff - CNT_BITS'(1);
      end

      rsp_strobe_in = cmd.respond;
      if (cmd.respond) begin
         rsp_in.data     = cmd.finish_read ? word_out(rd_data) : '0;
         rsp_in.status   = cmd.exec ? status_c : status_ff;
         rsp_in.count    = COUNT_W'(cnt_in);
         rsp_in.is_empty = (cnt_in == '0);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

[hdl/ring_buffer_deque.sv]
// channel    | ports                | handshake
// -----------+----------------------+------------------------------------------
// request    | start, busy, req_word| word taken on a clock edge with start & !busy
// response   | rsp_strobe, rsp_word | word valid for the one cycle rsp_strobe is high
//
// Push, set, resize without truncation and every failed operation go from the
// request register through the execute state to the response register; pop and
// get also pass a read state, as the store has a registered read port. A resize
// that shrinks walks the dropped slots, one store write a cycle, and clear walks
// all DEPTH slots. After reset the store is zeroed with busy held high.
// The response side cannot stall: each word is shown for exactly one cycle.
module ring_buffer_deque import rbd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   cmd_type       cmd;
   dp_status_type dp_status;

   rbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   rbd_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .dp_status  (dp_status),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule
